[src/tcg_pkg.sv]
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types and constants of the text cursor glyph renderer.
// ----------------------------------------------------------------------------
package tcg_pkg;

	// glyph height is fixed at one font byte
	localparam int GLYPH_ROWS = 8;
	localparam int ROW_W      = 3;
	localparam int COORD_W    = 11;
	localparam int ADDR_MAX_W = 11;

	// register reset values
	localparam logic [15:0] FG_RST     = 16'hFFFF;
	localparam logic [15:0] BG_RST     = 16'h0000;
	localparam logic [7:0]  LEFT_RST   = 8'd0;
	localparam logic [7:0]  TOP_RST    = 8'd0;
	localparam logic [7:0]  RIGHT_RST  = 8'd127;
	localparam logic [7:0]  BOTTOM_RST = 8'd159;

	typedef enum logic [2:0] {
		REG_FG     = 3'd0,
		REG_BG     = 3'd1,
		REG_LEFT   = 3'd2,
		REG_TOP    = 3'd3,
		REG_RIGHT  = 3'd4,
		REG_BOTTOM = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_PUT     = 3'd0,
		ACT_PUT_AT  = 3'd1,
		ACT_SET_POS = 3'd2,
		ACT_SAVE    = 3'd3,
		ACT_RESTORE = 3'd4,
		ACT_LOAD    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_WINDOW = 2'd1,
		KIND_PIXEL  = 2'd2
	} kind_t;

	typedef enum logic {
		JOB_GLYPH = 1'b0,
		JOB_FONT  = 1'b1
	} job_op_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_CLEAR  = 2'd1,
		BK_WINDOW = 2'd2,
		BK_PIXEL  = 2'd3
	} bk_state_t;

	typedef struct packed {
		logic [15:0] fg;
		logic [15:0] bg;
		logic [7:0]  left;
		logic [7:0]  top;
		logic [7:0]  right;
		logic [7:0]  bottom;
	} cfg_t;

	// one entry of the front-to-back queue
	typedef struct packed {
		job_op_t                 op;
		logic                    clear;
		logic [COORD_W-1:0]      clr_top;
		logic [COORD_W-1:0]      clr_bottom;
		logic [COORD_W-1:0]      win_left;
		logic [COORD_W-1:0]      win_top;
		logic [COORD_W-1:0]      win_right;
		logic [COORD_W-1:0]      win_bottom;
		logic [ADDR_MAX_W-1:0]   addr;
		logic [7:0]              data;
	} job_t;

endpackage

[src/tcg_front.sv]
// ----------------------------------------------------------------------------
// tcg_front
// Accepts items, resolves cursor movement and wrapping, queues draw/load jobs.
// ----------------------------------------------------------------------------
module tcg_front #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_SCALE   = 1,
	parameter int CHAR_COUNT    = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcg_pkg::cfg_t       cfg,
	input  logic                home,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          action,
	input  logic [7:0]          char_code,
	input  logic [7:0]          text_col,
	input  logic [7:0]          text_row,
	input  logic [10:0]         font_index,
	input  logic [7:0]          font_byte,
	output logic                job_push,
	output tcg_pkg::job_t       job,
	input  logic                q_full
);

	localparam int CELL_W      = GLYPH_COLUMNS * GLYPH_SCALE;
	localparam int CELL_H      = tcg_pkg::GLYPH_ROWS * GLYPH_SCALE;
	localparam int STORE_DEPTH = CHAR_COUNT * GLYPH_COLUMNS;
	localparam int CW          = tcg_pkg::COORD_W;

	logic            valid_s1;
	logic [2:0]      action_s1;
	logic [CW-1:0]   pos_x_s1;
	logic [CW-1:0]   pos_y_s1;
	logic [10:0]     base_s1;
	logic [10:0]     font_index_s1;
	logic [7:0]      font_byte_s1;
	logic            load_ok_s1;

	logic [CW-1:0]   cursor_x_q, cursor_y_q, saved_x_q, saved_y_q;

	logic            accept, advance, needs_push, is_put;
	logic [13:0]     px, py;
	logic [CW-1:0]   pos_x, pos_y;
	logic [8:0]      code_m;
	logic [CW-1:0]   sx, sy, ny1, nx, ny, ex, ey;
	logic [CW:0]     ex0, ey1;
	logic            wrap, wrap_y;

	// set_position math does not depend on the cursor: resolve at accept
	always_comb begin
		px = 14'(cfg.left) + 14'(text_col) * 14'(CELL_W);
		py = 14'(cfg.top) + 14'(text_row) * 14'(CELL_H);
		pos_x = (px > 14'(cfg.right)) ? CW'(cfg.left) : px[CW-1:0];
		pos_y = (py > 14'(cfg.bottom)) ? CW'(cfg.top) : py[CW-1:0];
		code_m = (9'(char_code) >= 9'(CHAR_COUNT)) ? 9'(char_code) - 9'(CHAR_COUNT)
			: 9'(char_code);
	end

	always_comb begin
		is_put = (action_s1 == tcg_pkg::ACT_PUT) || (action_s1 == tcg_pkg::ACT_PUT_AT);
		needs_push = is_put || ((action_s1 == tcg_pkg::ACT_LOAD) && load_ok_s1);
		advance = valid_s1 && !(needs_push && q_full);
		in_stall = valid_s1 && !advance;
		accept = in_valid && !in_stall;
	end

	// glyph placement and line wrap
	always_comb begin
		sx = (action_s1 == tcg_pkg::ACT_PUT_AT) ? pos_x_s1 : cursor_x_q;
		sy = (action_s1 == tcg_pkg::ACT_PUT_AT) ? pos_y_s1 : cursor_y_q;
		ex0 = (CW+1)'(sx) + (CW+1)'(CELL_W);
		wrap = ex0 > (CW+1)'(cfg.right);
		ny1 = sy + CW'(CELL_H);
		ey1 = (CW+1)'(ny1) + (CW+1)'(CELL_H);
		wrap_y = ey1 > (CW+1)'(cfg.bottom);
		nx = wrap ? CW'(cfg.left) : sx;
		ny = wrap ? (wrap_y ? CW'(cfg.top) : ny1) : sy;
		ex = nx + CW'(CELL_W);
		ey = ny + CW'(CELL_H);
	end

	always_comb begin
		job_push = advance && needs_push;
		job.op = is_put ? tcg_pkg::JOB_GLYPH : tcg_pkg::JOB_FONT;
		job.clear = wrap;
		job.clr_top = ny;
		job.clr_bottom = ey;
		job.win_left = nx;
		job.win_top = ny;
		job.win_right = ex;
		job.win_bottom = ey;
		job.addr = is_put ? base_s1 : font_index_s1;
		job.data = font_byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			base_s1 <= 11'(code_m) * 11'(GLYPH_COLUMNS);
			font_index_s1 <= font_index;
			font_byte_s1 <= font_byte;
			load_ok_s1 <= 12'(font_index) < 12'(STORE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= CW'(tcg_pkg::LEFT_RST);
			cursor_y_q <= CW'(tcg_pkg::TOP_RST);
			saved_x_q <= CW'(tcg_pkg::LEFT_RST);
			saved_y_q <= CW'(tcg_pkg::TOP_RST);
		end else if (home) begin
			cursor_x_q <= CW'(cfg.left);
			cursor_y_q <= CW'(cfg.top);
			saved_x_q <= CW'(cfg.left);
			saved_y_q <= CW'(cfg.top);
		end else if (advance) begin
			case (action_s1)
				tcg_pkg::ACT_PUT, tcg_pkg::ACT_PUT_AT: begin
					cursor_x_q <= ex;
					cursor_y_q <= ny;
				end
				tcg_pkg::ACT_SET_POS: begin
					cursor_x_q <= pos_x_s1;
					cursor_y_q <= pos_y_s1;
				end
				tcg_pkg::ACT_SAVE: begin
					saved_x_q <= cursor_x_q;
					saved_y_q <= cursor_y_q;
				end
				tcg_pkg::ACT_RESTORE: begin
					cursor_x_q <= saved_x_q;
					cursor_y_q <= saved_y_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[src/tcg_queue.sv]
// ----------------------------------------------------------------------------
// tcg_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module tcg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcg_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output tcg_pkg::job_t  head
);

	tcg_pkg::job_t  entry_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;

	assign full  = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

endmodule

[src/tcg_back.sv]
// ----------------------------------------------------------------------------
// tcg_back
// Executes queued jobs: font store writes and glyph command/pixel streams.
// ----------------------------------------------------------------------------
module tcg_back #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_SCALE   = 1,
	parameter int CHAR_COUNT    = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tcg_pkg::cfg_t  cfg,
	input  logic           job_valid,
	input  tcg_pkg::job_t  job,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     kind,
	output logic [10:0]    rect_left,
	output logic [10:0]    rect_top,
	output logic [10:0]    rect_right,
	output logic [10:0]    rect_bottom,
	output logic [15:0]    color,
	output logic           last
);

	localparam int STORE_DEPTH = CHAR_COUNT * GLYPH_COLUMNS;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int COL_W       = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
	localparam int SC_W        = (GLYPH_SCALE > 1) ? $clog2(GLYPH_SCALE) : 1;
	localparam int RW          = tcg_pkg::ROW_W;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);
	localparam logic [SC_W-1:0]  SC_LAST  = SC_W'(GLYPH_SCALE - 1);
	localparam logic [RW-1:0]    ROW_LAST = RW'(tcg_pkg::GLYPH_ROWS - 1);

	logic [7:0]  font_mem [STORE_DEPTH];
	logic [7:0]  rd_data_q;
	logic [AW-1:0] rd_addr;

	tcg_pkg::bk_state_t state_q, state_d;
	tcg_pkg::job_t      job_q;
	logic [COL_W-1:0]   col_q, col_nxt;
	logic [SC_W-1:0]    rep_q, rep2_q;
	logic [RW-1:0]      bit_q;
	logic [7:0]         bits_q, cur_bits;
	logic               first_q;

	logic               slot_free, emit;
	logic               row_end, col_end, glyph_end;
	logic [1:0]         e_kind;
	logic [10:0]        e_left, e_top, e_right, e_bottom;
	logic [15:0]        e_color;
	logic               e_last;

	logic               out_valid_q, last_q;
	logic [1:0]         kind_q;
	logic [10:0]        left_q, top_q, right_q, bottom_q;
	logic [15:0]        color_q;

	assign slot_free = !out_valid_q || !out_stall;
	assign cur_bits  = first_q ? rd_data_q : bits_q;
	assign row_end   = (bit_q == ROW_LAST) && (rep2_q == SC_LAST);
	assign col_end   = row_end && (rep_q == SC_LAST);
	assign glyph_end = col_end && (col_q == COL_LAST);
	// prefetch the next column byte while the current one is drawn
	assign col_nxt   = (col_q == COL_LAST) ? '0 : col_q + COL_W'(1);
	assign rd_addr   = job_q.addr[AW-1:0] +
		((state_q == tcg_pkg::BK_PIXEL) ? AW'(col_nxt) : '0);

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		emit = 1'b0;
		e_kind = tcg_pkg::KIND_PIXEL;
		e_left = '0;
		e_top = '0;
		e_right = '0;
		e_bottom = '0;
		e_color = '0;
		e_last = 1'b0;
		case (state_q)
			tcg_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					if (job.op == tcg_pkg::JOB_GLYPH) begin
						state_d = job.clear ? tcg_pkg::BK_CLEAR : tcg_pkg::BK_WINDOW;
					end
				end
			end
			tcg_pkg::BK_CLEAR: begin
				if (slot_free) begin
					emit = 1'b1;
					e_kind = tcg_pkg::KIND_CLEAR;
					e_left = 11'(cfg.left);
					e_top = job_q.clr_top;
					e_right = 11'(cfg.right);
					e_bottom = job_q.clr_bottom;
					e_color = cfg.bg;
					state_d = tcg_pkg::BK_WINDOW;
				end
			end
			tcg_pkg::BK_WINDOW: begin
				if (slot_free) begin
					emit = 1'b1;
					e_kind = tcg_pkg::KIND_WINDOW;
					e_left = job_q.win_left;
					e_top = job_q.win_top;
					e_right = job_q.win_right;
					e_bottom = job_q.win_bottom;
					state_d = tcg_pkg::BK_PIXEL;
				end
			end
			tcg_pkg::BK_PIXEL: begin
				if (slot_free) begin
					emit = 1'b1;
					e_kind = tcg_pkg::KIND_PIXEL;
					e_color = cur_bits[bit_q] ? cfg.fg : cfg.bg;
					e_last = glyph_end;
					if (glyph_end) state_d = tcg_pkg::BK_IDLE;
				end
			end
			default: state_d = tcg_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcg_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop && job.op == tcg_pkg::JOB_FONT) font_mem[job.addr[AW-1:0]] <= job.data;
		rd_data_q <= font_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (state_q == tcg_pkg::BK_WINDOW && emit) begin
			first_q <= 1'b1;
		end else if (state_q == tcg_pkg::BK_PIXEL) begin
			first_q <= 1'b0;
		end
	end

	// pixel walk: column, column repeat, row bit, bit repeat
	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		if (state_q == tcg_pkg::BK_WINDOW && emit) begin
			col_q <= '0;
			rep_q <= '0;
			bit_q <= '0;
			rep2_q <= '0;
		end
		if (state_q == tcg_pkg::BK_PIXEL) begin
			if (first_q) bits_q <= rd_data_q;
			if (emit) begin
				if (rep2_q == SC_LAST) begin
					rep2_q <= '0;
					if (bit_q == ROW_LAST) begin
						bit_q <= '0;
						if (rep_q == SC_LAST) begin
							rep_q <= '0;
							col_q <= col_nxt;
							bits_q <= rd_data_q;
						end else begin
							rep_q <= rep_q + SC_W'(1);
						end
					end else begin
						bit_q <= bit_q + RW'(1);
					end
				end else begin
					rep2_q <= rep2_q + SC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			left_q <= e_left;
			top_q <= e_top;
			right_q <= e_right;
			bottom_q <= e_bottom;
			color_q <= e_color;
			last_q <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign rect_left   = left_q;
	assign rect_top    = top_q;
	assign rect_right  = right_q;
	assign rect_bottom = bottom_q;
	assign color       = color_q;
	assign last        = last_q;

endmodule

[src/text_cursor_glyph_renderer_core.sv]
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer_core
// Text-console character generator: cursor, saved cursor, loadable font.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): one action per transfer: put char,
//    put char at text position, set position, save/restore cursor, or load
//    one font byte. Actions other than the two puts produce no results.
//  - Output channel (out_valid/out_stall): per put, an optional clear
//    rectangle (on line wrap), one window command, then
//    GLYPH_COLUMNS*8*GLYPH_SCALE^2 pixel colors; last marks the final pixel.
//  - Config port (cfg_we/cfg_index/cfg_data): write only while idle. Any area
//    register write homes cursor and saved cursor.
//  - Path: an input is registered in the front end, passes the job queue
//    and is taken by the back end from its idle state; results leave
//    through the output register, one result per cycle while out_stall is
//    low. Cursor actions pass the front end and overlap with glyph drawing;
//    a font load also passes the back end, after any glyph queued ahead of it.
//  - Rate is set by the back end's single output register (one pixel/cycle
//    if not stalled); the front end and a two-entry job queue run ahead of it.
//  - Reset clears control state and restores register defaults; font store
//    content is undefined until loaded.
//  - out_stall holds the output register; the queue then fills and in_stall
//    rises, with no result lost.
// ----------------------------------------------------------------------------
module text_cursor_glyph_renderer_core #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_SCALE   = 1,
	parameter int CHAR_COUNT    = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	// input channel
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [2:0]   action,
	input  logic [7:0]   char_code,
	input  logic [7:0]   text_col,
	input  logic [7:0]   text_row,
	input  logic [10:0]  font_index,
	input  logic [7:0]   font_byte,
	// output channel
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   kind,
	output logic [10:0]  rect_left,
	output logic [10:0]  rect_top,
	output logic [10:0]  rect_right,
	output logic [10:0]  rect_bottom,
	output logic [15:0]  color,
	output logic         last
);

	tcg_pkg::cfg_t  cfg_q;
	logic           home;

	logic           q_push, q_full, q_pop, q_valid;
	tcg_pkg::job_t  push_job, head_job;

	// configuration registers; an area write re-homes both cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg <= tcg_pkg::FG_RST;
			cfg_q.bg <= tcg_pkg::BG_RST;
			cfg_q.left <= tcg_pkg::LEFT_RST;
			cfg_q.top <= tcg_pkg::TOP_RST;
			cfg_q.right <= tcg_pkg::RIGHT_RST;
			cfg_q.bottom <= tcg_pkg::BOTTOM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tcg_pkg::REG_FG:     cfg_q.fg <= cfg_data;
				tcg_pkg::REG_BG:     cfg_q.bg <= cfg_data;
				tcg_pkg::REG_LEFT:   cfg_q.left <= cfg_data[7:0];
				tcg_pkg::REG_TOP:    cfg_q.top <= cfg_data[7:0];
				tcg_pkg::REG_RIGHT:  cfg_q.right <= cfg_data[7:0];
				tcg_pkg::REG_BOTTOM: cfg_q.bottom <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// home in the cycle after the write so the cursors take the new area value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home <= 1'b0;
		end else begin
			home <= cfg_we && (cfg_index == tcg_pkg::REG_LEFT ||
				cfg_index == tcg_pkg::REG_TOP || cfg_index == tcg_pkg::REG_RIGHT ||
				cfg_index == tcg_pkg::REG_BOTTOM);
		end
	end

	tcg_front #(
		.GLYPH_COLUMNS (GLYPH_COLUMNS),
		.GLYPH_SCALE   (GLYPH_SCALE),
		.CHAR_COUNT    (CHAR_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.home       (home),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.char_code  (char_code),
		.text_col   (text_col),
		.text_row   (text_row),
		.font_index (font_index),
		.font_byte  (font_byte),
		.job_push   (q_push),
		.job        (push_job),
		.q_full     (q_full)
	);

	tcg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_job)
	);

	tcg_back #(
		.GLYPH_COLUMNS (GLYPH_COLUMNS),
		.GLYPH_SCALE   (GLYPH_SCALE),
		.CHAR_COUNT    (CHAR_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.job_valid   (q_valid),
		.job         (head_job),
		.job_pop     (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_right  (rect_right),
		.rect_bottom (rect_bottom),
		.color       (color),
		.last        (last)
	);

	// the front end never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("job pushed into full queue");

	// the back end never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("job popped from empty queue");

	// only a pixel closes a glyph
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (kind == tcg_pkg::KIND_PIXEL))
		else $error("last flag on a command result");

	// a clear rectangle transfer is followed at once by its window command
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && kind == tcg_pkg::KIND_CLEAR) |=>
		(out_valid && kind == tcg_pkg::KIND_WINDOW))
		else $error("clear not followed by window");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text cursor glyph renderer: drives actions with
// random idling on both channels and compares each command and pixel against
// an in-bench prediction of cursor, wrap and font behavior.
// ----------------------------------------------------------------------------
module tb_top;

	// block configuration, kept equal to the instance below
	localparam int GLYPH_COLUMNS = 5;
	localparam int GLYPH_SCALE   = 1;
	localparam int CHAR_COUNT    = 256;
	localparam int CELL_W        = GLYPH_COLUMNS * GLYPH_SCALE;
	localparam int CELL_H        = tcg_pkg::GLYPH_ROWS * GLYPH_SCALE;
	localparam int FONT_DEPTH    = CHAR_COUNT * GLYPH_COLUMNS;

	// action codes the block must ignore, register indexes past the map
	localparam logic [2:0] ACT_SPARE_A  = 3'd6;
	localparam logic [2:0] ACT_SPARE_B  = 3'd7;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// cycles to let queued non-drawing work finish before a config write
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 60;
	// cycles without any transfer before the run is declared hung
	localparam int HANG_LIMIT    = 2000;

	typedef struct {
		logic [2:0]  act;
		logic [7:0]  code;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [10:0] idx;
		logic [7:0]  data;
	} req_t;

	typedef struct {
		tcg_pkg::kind_t kind;
		logic [10:0]    left;
		logic [10:0]    top;
		logic [10:0]    right;
		logic [10:0]    bottom;
		logic [15:0]    color;
		logic           last;
	} draw_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [7:0]  char_code;
	logic [7:0]  text_col;
	logic [7:0]  text_row;
	logic [10:0] font_index;
	logic [7:0]  font_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [10:0] rect_left;
	logic [10:0] rect_top;
	logic [10:0] rect_right;
	logic [10:0] rect_bottom;
	logic [15:0] color;
	logic        last;

	text_cursor_glyph_renderer_core #(
		.GLYPH_COLUMNS(GLYPH_COLUMNS),
		.GLYPH_SCALE  (GLYPH_SCALE),
		.CHAR_COUNT   (CHAR_COUNT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.char_code  (char_code),
		.text_col   (text_col),
		.text_row   (text_row),
		.font_index (font_index),
		.font_byte  (font_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.rect_left  (rect_left),
		.rect_top   (rect_top),
		.rect_right (rect_right),
		.rect_bottom(rect_bottom),
		.color      (color),
		.last       (last)
	);

	// ------------------------------------------------------------------------
	// Predicted block state: registers, cursor pair, mark pair, font store.
	// Coordinates are kept as plain ints and masked to 11 bits where the
	// block truncates them.
	// ------------------------------------------------------------------------
	logic [15:0] fg_col;
	logic [15:0] bg_col;
	int          area_l, area_t, area_r, area_b;
	int          pen_x, pen_y, mark_x, mark_y;
	logic [7:0]  glyph_rom [0:FONT_DEPTH-1];
	bit          glyph_known [0:FONT_DEPTH-1];

	// codes whose every column has been loaded; only these get drawn
	int          ready_list[$];
	bit          on_list [0:CHAR_COUNT-1];

	// commands and pixels still owed by the block, oldest first
	draw_cmd_t   draw_queue[$];

	int          errors = 0;
	int          idle_cycles = 0;
	bit          quiet;
	int          gap_pct;

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic void park_cursors();
		pen_x  = area_l;
		pen_y  = area_t;
		mark_x = area_l;
		mark_y = area_t;
	endfunction

	function automatic void queue_cmd(tcg_pkg::kind_t k, int l, int t, int r, int b,
			logic [15:0] c, logic fin);
		draw_cmd_t cmd;
		cmd.kind   = k;
		cmd.left   = 11'(l);
		cmd.top    = 11'(t);
		cmd.right  = 11'(r);
		cmd.bottom = 11'(b);
		cmd.color  = c;
		cmd.last   = fin;
		draw_queue.push_back(cmd);
	endfunction

	// text position to pixels; an axis landing past its bound snaps home
	function automatic void place_cursor(logic [7:0] col, logic [7:0] row);
		int x;
		int y;
		x = area_l + int'(col) * CELL_W;
		y = area_t + int'(row) * CELL_H;
		pen_x = (x > area_r) ? area_l : x;
		pen_y = (y > area_b) ? area_t : y;
	endfunction

	function automatic void render_glyph(logic [7:0] code);
		int          ex, ey, base;
		int          c, rep, b, rep2;
		logic [7:0]  bits;
		logic [15:0] pix;
		ex   = pen_x + CELL_W;
		ey   = pen_y + CELL_H;
		base = (int'(code) % CHAR_COUNT) * GLYPH_COLUMNS;
		// line wrap: next text row, or back to the top, with a line clear
		if (ex > area_r) begin
			pen_x = area_l;
			ex    = pen_x + CELL_W;
			pen_y = (pen_y + CELL_H) & 'h7FF;
			ey    = pen_y + CELL_H;
			if (ey > area_b) begin
				pen_y = area_t;
				ey    = pen_y + CELL_H;
			end
			queue_cmd(tcg_pkg::KIND_CLEAR, area_l, pen_y, area_r, ey, bg_col, 1'b0);
		end
		queue_cmd(tcg_pkg::KIND_WINDOW, pen_x, pen_y, ex, ey, 16'h0000, 1'b0);
		// column by column, bit 0 first, each bit and column scaled
		for (c = 0; c < GLYPH_COLUMNS; c++) begin
			bits = glyph_rom[base + c];
			for (rep = 0; rep < GLYPH_SCALE; rep++)
				for (b = 0; b < tcg_pkg::GLYPH_ROWS; b++) begin
					pix = bits[b] ? fg_col : bg_col;
					for (rep2 = 0; rep2 < GLYPH_SCALE; rep2++)
						queue_cmd(tcg_pkg::KIND_PIXEL, 0, 0, 0, 0, pix,
							c == GLYPH_COLUMNS - 1 && rep == GLYPH_SCALE - 1 &&
							b == tcg_pkg::GLYPH_ROWS - 1 && rep2 == GLYPH_SCALE - 1);
				end
		end
		pen_x = ex & 'h7FF;
	endfunction

	function automatic void predict_action(req_t r);
		case (r.act)
			tcg_pkg::ACT_PUT: begin
				render_glyph(r.code);
			end
			tcg_pkg::ACT_PUT_AT: begin
				place_cursor(r.col, r.row);
				render_glyph(r.code);
			end
			tcg_pkg::ACT_SET_POS: begin
				place_cursor(r.col, r.row);
			end
			tcg_pkg::ACT_SAVE: begin
				mark_x = pen_x;
				mark_y = pen_y;
			end
			tcg_pkg::ACT_RESTORE: begin
				pen_x = mark_x;
				pen_y = mark_y;
			end
			tcg_pkg::ACT_LOAD: begin
				// loads past the store are dropped
				if (r.idx < FONT_DEPTH) begin
					glyph_rom[r.idx]   = r.data;
					glyph_known[r.idx] = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checking: every output transfer pops the oldest expectation
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin : check_results
		draw_cmd_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (draw_queue.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d", kind));
			end else begin
				want = draw_queue.pop_front();
				if (kind !== want.kind)
					flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (rect_left !== want.left)
					flag_mismatch($sformatf("rect_left %0d, want %0d", rect_left, want.left));
				if (rect_top !== want.top)
					flag_mismatch($sformatf("rect_top %0d, want %0d", rect_top, want.top));
				if (rect_right !== want.right)
					flag_mismatch($sformatf("rect_right %0d, want %0d",
						rect_right, want.right));
				if (rect_bottom !== want.bottom)
					flag_mismatch($sformatf("rect_bottom %0d, want %0d",
						rect_bottom, want.bottom));
				if (color !== want.color)
					flag_mismatch($sformatf("color %h, want %h", color, want.color));
				if (last !== want.last)
					flag_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	// hang detection: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, HANG_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// output back-pressure: runs of random length, stalled or not; off when quiet
	initial begin : drive_out_stall
		int run;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			run = $urandom_range(1, 13);
			out_stall = !quiet && ($urandom_range(0, 99) < gap_pct);
			repeat (run - 1) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// one input transfer; valid stays high on return so back-to-back items
	// need no extra assignment
	task automatic send_item(req_t r);
		int gap;
		gap = (!quiet && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		action     = r.act;
		char_code  = r.code;
		text_col   = r.col;
		text_row   = r.row;
		font_index = r.idx;
		font_byte  = r.data;
		in_valid   = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_action(r);
	endtask

	// fields an action does not use still carry random bits
	function automatic req_t scramble_req();
		req_t r;
		r.act  = tcg_pkg::ACT_PUT;
		r.code = 8'($urandom);
		r.col  = 8'($urandom);
		r.row  = 8'($urandom);
		r.idx  = 11'($urandom);
		r.data = 8'($urandom);
		return r;
	endfunction

	task automatic issue(logic [2:0] act, logic [7:0] code, logic [7:0] col,
			logic [7:0] row);
		req_t r;
		r      = scramble_req();
		r.act  = act;
		r.code = code;
		r.col  = col;
		r.row  = row;
		send_item(r);
	endtask

	task automatic load_byte(logic [10:0] idx, logic [7:0] data);
		req_t r;
		r      = scramble_req();
		r.act  = tcg_pkg::ACT_LOAD;
		r.idx  = idx;
		r.data = data;
		send_item(r);
	endtask

	// full glyph load; column 0 sits in the low byte
	task automatic load_glyph(int code, logic [39:0] cols);
		int  c;
		bit  ready;
		for (c = 0; c < GLYPH_COLUMNS; c++)
			load_byte(11'(code * GLYPH_COLUMNS + c), cols[8*c +: 8]);
		ready = 1'b1;
		for (c = 0; c < GLYPH_COLUMNS; c++)
			ready &= glyph_known[code * GLYPH_COLUMNS + c];
		if (ready && !on_list[code]) begin
			ready_list.push_back(code);
			on_list[code] = 1'b1;
		end
	endtask

	function automatic logic [39:0] random_columns();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return '1;
			default: return {8'($urandom), 32'($urandom)};
		endcase
	endfunction

	function automatic logic [7:0] pick_code();
		return 8'(ready_list[$urandom_range(0, ready_list.size() - 1)]);
	endfunction

	// mostly positions that land inside a full-size area, sometimes anything
	function automatic logic [7:0] pick_col();
		return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 55)) : 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_row();
		return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 33)) : 8'($urandom);
	endfunction

	// configuration write; the model follows at the same edge
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			tcg_pkg::REG_FG:     fg_col = val;
			tcg_pkg::REG_BG:     bg_col = val;
			tcg_pkg::REG_LEFT:   begin area_l = int'(val[7:0]); park_cursors(); end
			tcg_pkg::REG_TOP:    begin area_t = int'(val[7:0]); park_cursors(); end
			tcg_pkg::REG_RIGHT:  begin area_r = int'(val[7:0]); park_cursors(); end
			tcg_pkg::REG_BOTTOM: begin area_b = int'(val[7:0]); park_cursors(); end
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drop valid, drain every owed result, then let queued loads retire
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (draw_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// random traffic: mostly draws and full glyph loads, some cursor moves,
	// a little noise (dropped loads, unused actions) that is not counted
	task automatic run_mix(int count);
		int done;
		int pick;
		logic [10:0] idx;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				issue(tcg_pkg::ACT_PUT, pick_code(), 8'($urandom), 8'($urandom));
				done++;
			end else if (pick < 55) begin
				issue(tcg_pkg::ACT_PUT_AT, pick_code(), pick_col(), pick_row());
				done++;
			end else if (pick < 63) begin
				issue(tcg_pkg::ACT_SET_POS, 8'($urandom), pick_col(), pick_row());
				done++;
			end else if (pick < 68) begin
				issue(tcg_pkg::ACT_SAVE, 8'($urandom), 8'($urandom), 8'($urandom));
				done++;
			end else if (pick < 73) begin
				issue(tcg_pkg::ACT_RESTORE, 8'($urandom), 8'($urandom), 8'($urandom));
				done++;
			end else if (pick < 88) begin
				load_glyph($urandom_range(0, CHAR_COUNT - 1), random_columns());
				done += GLYPH_COLUMNS;
			end else if (pick < 93) begin
				// stray single byte anywhere in the index range
				idx = 11'($urandom);
				load_byte(idx, 8'($urandom));
				if (idx < FONT_DEPTH)
					done++;
			end else begin
				issue(($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B,
					8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// reset config: font extremes, ignored inputs, every action, both wraps
	task automatic test_directed();
		gap_pct = 25;
		load_glyph(0, {8'h5A, 8'h00, 8'hFF, 8'h80, 8'h01});
		load_glyph(CHAR_COUNT - 1, random_columns());
		load_byte(11'h7FF, 8'hFF);                       // past the store
		issue(ACT_SPARE_A, 8'hFF, 8'hFF, 8'hFF);
		issue(ACT_SPARE_B, 8'h00, 8'h00, 8'h00);
		issue(tcg_pkg::ACT_PUT, 8'd0, 8'd0, 8'd0);
		issue(tcg_pkg::ACT_PUT, 8'd255, 8'd0, 8'd0);
		issue(tcg_pkg::ACT_PUT_AT, 8'd255, 8'd255, 8'd255);  // both axes off the area
		issue(tcg_pkg::ACT_SET_POS, 8'd0, 8'd25, 8'd19);     // last cell of last line
		issue(tcg_pkg::ACT_SAVE, 8'd0, 8'd0, 8'd0);
		issue(tcg_pkg::ACT_PUT, 8'd0, 8'd0, 8'd0);           // wraps back to the top
		issue(tcg_pkg::ACT_RESTORE, 8'd0, 8'd0, 8'd0);
		issue(tcg_pkg::ACT_PUT, 8'd255, 8'd0, 8'd0);
		issue(tcg_pkg::ACT_PUT_AT, 8'd0, 8'd24, 8'd3);
		issue(tcg_pkg::ACT_PUT, 8'd255, 8'd0, 8'd0);         // wraps to the next line
	endtask

	task automatic test_full_area();
		settle();
		write_reg(tcg_pkg::REG_FG, 16'($urandom));
		write_reg(tcg_pkg::REG_BG, 16'($urandom));
		write_reg(tcg_pkg::REG_LEFT, 16'd0);
		write_reg(tcg_pkg::REG_TOP, 16'd0);
		write_reg(tcg_pkg::REG_RIGHT, 16'd255);
		write_reg(tcg_pkg::REG_BOTTOM, 16'd255);
		gap_pct = 40;
		run_mix(40);
	endtask

	// area narrower than a glyph: every draw clears and overruns the bound;
	// run without any idling
	task automatic test_no_fit();
		settle();
		write_reg(tcg_pkg::REG_FG, 16'h0000);
		write_reg(tcg_pkg::REG_BG, 16'hFFFF);
		write_reg(tcg_pkg::REG_LEFT, 16'd250);
		write_reg(tcg_pkg::REG_RIGHT, 16'd252);
		write_reg(tcg_pkg::REG_TOP, 16'd100);
		write_reg(tcg_pkg::REG_BOTTOM, 16'd104);
		gap_pct = 0;
		run_mix(30);
	endtask

	// all-max and all-zero areas; upper data bits and spare indexes ignored
	task automatic test_area_extremes();
		settle();
		write_reg(tcg_pkg::REG_LEFT, {8'($urandom), 8'd255});
		write_reg(tcg_pkg::REG_TOP, {8'($urandom), 8'd255});
		write_reg(tcg_pkg::REG_RIGHT, 16'hFFFF);
		write_reg(tcg_pkg::REG_BOTTOM, {8'($urandom), 8'd255});
		write_reg(REG_SPARE_LO, 16'($urandom));
		write_reg(REG_SPARE_HI, 16'($urandom));
		gap_pct = 30;
		run_mix(20);
		settle();
		write_reg(tcg_pkg::REG_LEFT, 16'hFF00);
		write_reg(tcg_pkg::REG_TOP, 16'd0);
		write_reg(tcg_pkg::REG_RIGHT, 16'd0);
		write_reg(tcg_pkg::REG_BOTTOM, 16'd0);
		run_mix(20);
	endtask

	task automatic test_random_areas();
		repeat (3) begin
			settle();
			write_reg(tcg_pkg::REG_FG, 16'($urandom));
			write_reg(tcg_pkg::REG_BG, 16'($urandom));
			write_reg(tcg_pkg::REG_LEFT, 16'($urandom));
			write_reg(tcg_pkg::REG_TOP, 16'($urandom));
			write_reg(tcg_pkg::REG_RIGHT, 16'($urandom));
			write_reg(tcg_pkg::REG_BOTTOM, 16'($urandom));
			gap_pct = $urandom_range(10, 60);
			run_mix(20);
		end
	endtask

	// back to reset values, full rate on both sides to the end
	task automatic test_steady_tail();
		settle();
		write_reg(tcg_pkg::REG_FG, tcg_pkg::FG_RST);
		write_reg(tcg_pkg::REG_BG, tcg_pkg::BG_RST);
		write_reg(tcg_pkg::REG_LEFT, tcg_pkg::LEFT_RST);
		write_reg(tcg_pkg::REG_TOP, tcg_pkg::TOP_RST);
		write_reg(tcg_pkg::REG_RIGHT, tcg_pkg::RIGHT_RST);
		write_reg(tcg_pkg::REG_BOTTOM, tcg_pkg::BOTTOM_RST);
		quiet = 1'b1;
		run_mix(40);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = tcg_pkg::REG_FG;
		cfg_data   = 16'h0000;
		in_valid   = 1'b0;
		action     = tcg_pkg::ACT_PUT;
		char_code  = 8'h00;
		text_col   = 8'h00;
		text_row   = 8'h00;
		font_index = 11'h000;
		font_byte  = 8'h00;
		quiet      = 1'b0;
		gap_pct    = 0;

		// model starts from the register defaults
		fg_col = tcg_pkg::FG_RST;
		bg_col = tcg_pkg::BG_RST;
		area_l = int'(tcg_pkg::LEFT_RST);
		area_t = int'(tcg_pkg::TOP_RST);
		area_r = int'(tcg_pkg::RIGHT_RST);
		area_b = int'(tcg_pkg::BOTTOM_RST);
		park_cursors();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_area();
		test_no_fit();
		test_area_extremes();
		test_random_areas();
		test_steady_tail();

		@(negedge clk);
		in_valid = 1'b0;
		while (draw_queue.size() != 0) @(posedge clk);
		// anything arriving now has no expectation and is flagged
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[sim.f]
src/tcg_pkg.sv
src/tcg_front.sv
src/tcg_queue.sv
src/tcg_back.sv
src/text_cursor_glyph_renderer_core.sv
tb/sv/tb_top.sv
